@@ rtl/siwa_pkg.sv @@
`default_nettype none

package siwa_pkg;

    // Register and result field widths
    localparam int CFG_W           = 24;
    localparam int SHIFT_W         = 5;
    localparam int WIN_W           = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int OUT_W           = 25;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int OUT_TDW         = ((2 * OUT_W + 7) / 8) * 8;

    // Register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_CODE_OFFSET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_UNIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IIR_SHIFT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 2'd3;

    // Operand pair for the shared divider
    typedef enum logic [1:0] {
        DIV_AVG,
        DIV_FILT,
        DIV_HELD
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     update;
        logic     div_start;
        t_div_sel div_sel;
        logic     store_avg;
        logic     store_fv;
        logic     store_av;
        logic     set_err;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic block_done;
        logic cpu_zero;
        logic pending;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/siwa_div.sv @@
`default_nettype none

module siwa_div #(
    parameter int DVD_W = 34,
    parameter int DSR_W = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dmag;
    logic             r_neg;

    logic [DVD_W-1:0] w_dvd_mag;
    logic [DSR_W-1:0] w_dsr_mag;
    logic [DSR_W:0]   w_shift;
    logic [DSR_W:0]   w_trial;
    logic             w_ge;

    always_comb begin
        w_dvd_mag = i_dividend[DVD_W-1] ? (DVD_W'(0) - i_dividend) : i_dividend;
        w_dsr_mag = i_divisor[DSR_W-1] ? (DSR_W'(0) - i_divisor) : i_divisor;
        w_shift   = {r_rem, r_quo[DVD_W-1]};
        w_trial   = w_shift - {1'b0, r_dmag};
        w_ge      = !w_trial[DSR_W];
    end

    // Restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= w_dvd_mag;
            r_rem  <= '0;
            r_dmag <= w_dsr_mag;
            r_neg  <= i_dividend[DVD_W-1] ^ i_divisor[DSR_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DSR_W-1:0] : w_shift[DSR_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (DVD_W'(0) - r_quo) : r_quo;

endmodule

`default_nettype wire

@@ rtl/siwa_dp.sv @@
`default_nettype none

module siwa_dp
    import siwa_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_TDW      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [IN_TDW-1:0]    i_sample_tdata,
    input  wire logic                 i_sample_mode,
    input  wire logic                 i_out_ready,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    output logic                      o_out_valid,
    output logic [OUT_TDW-1:0]        o_out_tdata,
    output logic [1:0]                o_out_tuser
);

    localparam int XW   = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 1;
    localparam int DW   = XW + 1;
    localparam int SUMW = XW + 9;

    // Registers
    logic signed [CFG_W-1:0]   r_offset;
    logic signed [CFG_W-1:0]   r_cpu;
    logic        [SHIFT_W-1:0] r_shift;
    logic        [WIN_W-1:0]   r_window;

    logic signed [XW-1:0]   r_x;
    logic signed [XW-1:0]   r_filt;
    logic signed [XW-1:0]   r_held;
    logic signed [SUMW-1:0] r_sum;
    logic        [WIN_W-1:0] r_count;
    logic                   r_first;
    logic                   r_pending;

    logic [OUT_W-1:0] r_res_fv;
    logic [OUT_W-1:0] r_res_av;
    logic             r_res_valid;
    logic             r_res_err;

    logic [OUT_W-1:0] r_out_fv;
    logic [OUT_W-1:0] r_out_av;
    logic             r_out_valid_q;
    logic             r_out_avg_valid;
    logic             r_out_err;

    logic signed [XW-1:0]   w_x;
    logic signed [DW-1:0]   w_diff;
    logic        [DW-1:0]   w_mask;
    logic signed [DW-1:0]   w_biased;
    logic signed [DW-1:0]   w_corr;
    logic signed [XW-1:0]   n_filt;
    logic signed [SUMW-1:0] n_sum;
    logic                   w_block_done;
    logic [WIN_W:0]         w_n;

    logic [SUMW-1:0]  w_div_dvd;
    logic [CFG_W-1:0] w_div_dsr;
    logic             w_div_done;
    logic [SUMW-1:0]  w_div_q;

    always_comb begin
        w_x = {{(XW - SAMPLE_BITS){i_sample_tdata[SAMPLE_BITS-1]}},
               i_sample_tdata[SAMPLE_BITS-1:0]}
            - {{(XW - CFG_W){r_offset[CFG_W-1]}}, r_offset};

        // Signed shift that truncates toward zero: bias negative values first
        w_diff   = {r_x[XW-1], r_x} - {r_filt[XW-1], r_filt};
        w_mask   = ~({DW{1'b1}} << r_shift);
        w_biased = w_diff + (w_diff[DW-1] ? w_mask : DW'(0));
        if ({1'b0, r_shift} >= 6'(DW)) begin
            w_corr = '0;
        end else begin
            w_corr = w_biased >>> r_shift;
        end
        n_filt = r_filt + w_corr[XW-1:0];
        n_sum  = r_sum + {{(SUMW - XW){r_x[XW-1]}}, r_x};

        w_block_done = (r_count >= r_window);
        w_n          = {1'b0, r_count} + (WIN_W + 1)'(1);

        unique case (i_cmd.div_sel)
            DIV_AVG: begin
                w_div_dvd = r_sum;
                w_div_dsr = {{(CFG_W - WIN_W - 1){1'b0}}, w_n};
            end
            DIV_FILT: begin
                w_div_dvd = {{(SUMW - XW){r_filt[XW-1]}}, r_filt};
                w_div_dsr = r_cpu;
            end
            DIV_HELD: begin
                w_div_dvd = {{(SUMW - XW){r_held[XW-1]}}, r_held};
                w_div_dsr = r_cpu;
            end
            default: begin
                w_div_dvd = '0;
                w_div_dsr = r_cpu;
            end
        endcase
    end

    siwa_div #(
        .DVD_W (SUMW),
        .DSR_W (CFG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_cpu    <= '0;
            r_shift  <= '0;
            r_window <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CODE_OFFSET:     r_offset <= i_cfg_data;
                REG_COUNTS_PER_UNIT: r_cpu    <= i_cfg_data;
                REG_IIR_SHIFT:       r_shift  <= i_cfg_data[SHIFT_W-1:0];
                REG_WINDOW_SIZE:     r_window <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Filter and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_filt    <= '0;
            r_held    <= '0;
            r_sum     <= '0;
            r_count   <= '0;
            r_first   <= 1'b1;
            r_pending <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_first <= 1'b0;
                r_filt  <= r_first ? r_x : n_filt;
                r_sum   <= n_sum;
                if (!w_block_done) begin
                    r_count <= r_count + WIN_W'(1);
                end
            end
            if (i_cmd.store_avg) begin
                r_held    <= w_div_q[XW-1:0];
                r_sum     <= '0;
                r_count   <= '0;
                r_pending <= 1'b1;
            end
            if (i_cmd.store_av) begin
                r_pending <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= w_x;
        end
    end

    // Result assembly
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_err) begin
            r_res_fv    <= '0;
            r_res_av    <= '0;
            r_res_valid <= 1'b0;
            r_res_err   <= 1'b1;
        end else if (i_cmd.store_fv) begin
            r_res_fv    <= w_div_q[OUT_W-1:0];
            r_res_av    <= '0;
            r_res_valid <= 1'b0;
            r_res_err   <= 1'b0;
        end else if (i_cmd.store_av) begin
            r_res_av    <= w_div_q[OUT_W-1:0];
            r_res_valid <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid_q <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid_q <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid_q <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_fv        <= r_res_fv;
            r_out_av        <= r_res_av;
            r_out_avg_valid <= r_res_valid;
            r_out_err       <= r_res_err;
        end
    end

    always_comb begin
        o_stat.mode       = i_sample_mode;
        o_stat.block_done = w_block_done;
        o_stat.cpu_zero   = (r_cpu == '0);
        o_stat.pending    = r_pending;
        o_stat.div_done   = w_div_done;
        o_stat.out_free   = !r_out_valid_q || i_out_ready;
    end

    assign o_out_valid = r_out_valid_q;
    assign o_out_tdata = {{(OUT_TDW - 2 * OUT_W){1'b0}}, r_out_av, r_out_fv};
    assign o_out_tuser = {r_out_err, r_out_avg_valid};

endmodule

`default_nettype wire

@@ rtl/siwa_ctrl.sv @@
`default_nettype none

module siwa_ctrl
    import siwa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_AVG_GO,
        S_AVG_WAIT,
        S_CHK,
        S_FV_WAIT,
        S_AV_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.div_sel = DIV_FILT;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.mode) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_CHK;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.block_done ? S_AVG_GO : S_CHK;
            end
            S_AVG_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_AVG;
                n_state         = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.store_avg = 1'b1;
                    n_state         = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.cpu_zero) begin
                    // hold any pending average for a later request
                    o_cmd.set_err = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_FILT;
                    n_state         = S_FV_WAIT;
                end
            end
            S_FV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.store_fv = 1'b1;
                    if (i_stat.pending) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_HELD;
                        n_state         = S_AV_WAIT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_AV_WAIT: begin
                o_cmd.div_sel = DIV_HELD;
                if (i_stat.div_done) begin
                    o_cmd.store_av = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_AVG_WAIT || r_state == S_FV_WAIT
                             || r_state == S_AV_WAIT))
        else $error("divider finished outside a wait state");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_state == S_IDLE)
        else $error("result load did not return to idle");

    a_clear_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |=> !o_cmd.update)
        else $error("clear request went on to a filter update");

endmodule

`default_nettype wire

@@ rtl/sensor_iir_and_window_average.sv @@
`default_nettype none

// Channel   Dir  Payload
// s_axis    in   tdata: sample_code; tuser: mode
// m_axis    out  tdata: filtered_value, average_value; tuser: average_valid, divide_error
// i_cfg_*   in   index 0 code_offset, 1 counts_per_unit, 2 iir_shift, 3 window_size
//
// One request at a time. The shared serial divider works on a dividend of
// max(SAMPLE_BITS,24)+10 bits (34 by default). A request with a nonzero
// counts_per_unit runs one division for the filtered value, and a sample also runs
// one when its block completes and one more when a held average goes out.
// Reset is synchronous and clears registers, filter and block state.
// The finished result waits in the output register while the next request is taken.

module sensor_iir_and_window_average
    import siwa_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // sample_code
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // mode
    input  wire logic [0:0]           s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // filtered_value, average_value
    output logic [OUT_TDW-1:0]        m_axis_tdata,
    // average_valid, divide_error
    output logic [1:0]                m_axis_tuser
);

    localparam int IN_TDW = ((SAMPLE_BITS + 7) / 8) * 8;

    t_cmd  w_cmd;
    t_stat w_stat;

    siwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    siwa_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_TDW      (IN_TDW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_tdata (s_axis_tdata),
        .i_sample_mode  (s_axis_tuser[0]),
        .i_out_ready    (m_axis_tready),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (m_axis_tvalid),
        .o_out_tdata    (m_axis_tdata),
        .o_out_tuser    (m_axis_tuser)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (m_axis_tdata == '0 && !m_axis_tuser[0]))
        else $error("divide error result carries nonzero values");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one is in work");

    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_done |-> !s_axis_tready)
        else $error("divider finished while the block is idle");

endmodule

`default_nettype wire

@@ test/sensor_iir_and_window_average_test.sv @@
`default_nettype none

module sensor_iir_and_window_average_test;
    import siwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_PHASES  = 11;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic signed [OUT_W-1:0] average;
        logic                    avg_valid;
        logic                    div_err;
    } sensor_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   mode;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic signed [CFG_W-1:0] value;
        logic                   typed;
        sensor_result_t         want;
    } directed_row_t;

    localparam sensor_result_t PREDICTED = '0;
    localparam sensor_result_t ERR_ONLY  = '{'0, '0, 1'b0, 1'b1};

    // Directed rows: extremes, clears, zero divisor with a held average,
    // large shift, shrunk window. Typed expectations only where obvious.
    localparam directed_row_t DIRECTED_ROWS [40] = '{
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh7FFFFF, 1'b1, ERR_ONLY},
        '{ROW_ITEM,  MODE_CLEAR,  REG_CODE_OFFSET,     24'sh5A5A5A, 1'b1, ERR_ONLY},
        '{ROW_WRITE, MODE_SAMPLE, REG_COUNTS_PER_UNIT, 24'sd1,      1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh7FFFFF, 1'b1,
          '{25'sd8388607, 25'sd8388607, 1'b1, 1'b0}},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh800000, 1'b1,
          '{-25'sd8388608, -25'sd8388608, 1'b1, 1'b0}},
        '{ROW_ITEM,  MODE_CLEAR,  REG_CODE_OFFSET,     24'shA5A5A5, 1'b1, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_CODE_OFFSET,     24'sh7FFFFF, 1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh800000, 1'b1,
          '{-25'sd16777215, -25'sd16777215, 1'b1, 1'b0}},
        '{ROW_WRITE, MODE_SAMPLE, REG_CODE_OFFSET,     24'sh800000, 1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh7FFFFF, 1'b1,
          '{25'sd16777215, 25'sd16777215, 1'b1, 1'b0}},
        '{ROW_WRITE, MODE_SAMPLE, REG_COUNTS_PER_UNIT, -24'sd1,     1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd0,      1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_COUNTS_PER_UNIT, 24'sh800000, 1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_IIR_SHIFT,       24'sd24,     1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_WINDOW_SIZE,     24'sd3,      1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd1000,   1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     -24'sd1000,  1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh7FFFFF, 1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh800000, 1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_IIR_SHIFT,       24'sd31,     1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd12345,  1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     -24'sd77,    1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_COUNTS_PER_UNIT, 24'sd0,      1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_WINDOW_SIZE,     24'sd1,      1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd500,    1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd600,    1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_COUNTS_PER_UNIT, 24'sd7,      1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_WINDOW_SIZE,     24'sd255,    1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd700,    1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd800,    1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     -24'sd900,   1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd1,      1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_WINDOW_SIZE,     24'sd1,      1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sd2,      1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_CODE_OFFSET,     24'sd0,      1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_COUNTS_PER_UNIT, 24'sh7FFFFF, 1'b0, PREDICTED},
        '{ROW_WRITE, MODE_SAMPLE, REG_IIR_SHIFT,       24'sd3,      1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_CLEAR,  REG_CODE_OFFSET,     24'sh123456, 1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh7FFFFF, 1'b0, PREDICTED},
        '{ROW_ITEM,  MODE_SAMPLE, REG_CODE_OFFSET,     24'sh800000, 1'b0, PREDICTED}
    };

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]              i_cfg_index   = '0;
    logic [CFG_W-1:0]                  i_cfg_data    = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [SAMPLE_BITS_DEF-1:0]        s_axis_tdata  = '0;   // sample_code
    logic [0:0]                        s_axis_tuser  = '0;   // mode
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [OUT_TDW-1:0]                m_axis_tdata;         // filtered_value, average_value
    logic [1:0]                        m_axis_tuser;         // average_valid, divide_error

    // Shadow copy of the registers and the filter/averaging state
    longint reg_offset;
    longint reg_cpu;
    int     reg_shift;
    int     reg_window;
    longint flt_state;
    bit     seed_pending;
    longint blk_sum;
    int     blk_count;
    longint held_avg;
    bit     avg_ready;

    sensor_result_t expected_results[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    int n_requests  = 0;
    int n_clears    = 0;
    int n_results   = 0;
    int n_averages  = 0;
    int n_div_err   = 0;
    int n_writes    = 0;
    int n_fail      = 0;
    int stall_count = 0;

    sensor_iir_and_window_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_conditioning();
        flt_state    = 0;
        seed_pending = 1'b1;
        blk_sum      = 0;
        blk_count    = 0;
        held_avg     = 0;
        avg_ready    = 1'b0;
    endfunction

    function automatic sensor_result_t predict_conditioned(input logic mode,
                                                           input logic [CFG_W-1:0] code);
        sensor_result_t r;
        longint         x;
        r = '0;
        if (mode == MODE_CLEAR) begin
            clear_conditioning();
        end else begin
            x = longint'($signed(code)) - reg_offset;
            if (seed_pending) begin
                seed_pending = 1'b0;
                flt_state    = x;
            end else begin
                flt_state = flt_state + (x - flt_state) / (longint'(1) << reg_shift);
            end
            blk_sum = blk_sum + x;
            // close the block once it holds window_size+1 samples, or more after a shrink
            if (blk_count >= reg_window) begin
                held_avg  = blk_sum / longint'(blk_count + 1);
                blk_sum   = 0;
                blk_count = 0;
                avg_ready = 1'b1;
            end else begin
                blk_count++;
            end
        end
        if (reg_cpu == 0) begin
            r.div_err = 1'b1;
        end else begin
            r.filtered = OUT_W'(flt_state / reg_cpu);
            if (avg_ready) begin
                avg_ready   = 1'b0;
                r.average   = OUT_W'(held_avg / reg_cpu);
                r.avg_valid = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CODE_OFFSET:     reg_offset = longint'($signed(data));
            REG_COUNTS_PER_UNIT: reg_cpu    = longint'($signed(data));
            REG_IIR_SHIFT:       reg_shift  = int'(data[SHIFT_W-1:0]);
            REG_WINDOW_SIZE:     reg_window = int'(data[WIN_W-1:0]);
            default: ;
        endcase
        n_writes++;
        @(posedge i_clk);
    endtask

    task automatic push_request(input logic mode, input logic [CFG_W-1:0] code,
                                input bit typed, input sensor_result_t typed_want);
        sensor_result_t want;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= code;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want = predict_conditioned(mode, code);
        if (typed) want = typed_want;
        expected_results.push_back(want);
        n_requests++;
        if (mode == MODE_CLEAR) n_clears++;
    endtask

    // Hold the input until every result is back, then let the clock run on while idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            1, 2: return CFG_W'(reg_offset + longint'($urandom_range(0, 200)) - 100);
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic randomize_registers(input bit wide_window);
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = 24'h7FFFFF;
            2: v = 24'h800000;
            default: v = CFG_W'($urandom);
        endcase
        write_register(REG_CODE_OFFSET, v);
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = 24'd1;
            2: v = 24'hFFFFFF;
            3: v = 24'h7FFFFF;
            4: v = 24'h800000;
            5, 6, 7: v = $urandom_range(0, 1) ? CFG_W'($urandom_range(1, 64))
                                              : CFG_W'(-$urandom_range(1, 64));
            default: v = CFG_W'($urandom);
        endcase
        if (wide_window && v == '0) v = 24'd3;
        write_register(REG_COUNTS_PER_UNIT, v);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = CFG_W'($urandom_range(0, 4));
            4, 5, 6: v = CFG_W'($urandom_range(5, 12));
            7: v = 24'd24;
            8: v = CFG_W'($urandom_range(25, 31));
            default: v = CFG_W'($urandom_range(0, 31));
        endcase
        write_register(REG_IIR_SHIFT, v);
        if (wide_window) begin
            v = 24'd255;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: v = CFG_W'($urandom_range(0, 3));
                6, 7, 8: v = CFG_W'($urandom_range(4, 15));
                default: v = CFG_W'($urandom_range(16, 255));
            endcase
        end
        write_register(REG_WINDOW_SIZE, v);
    endtask

    // Receiver: random backpressure, plus one long hold on request
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        sensor_result_t got;
        sensor_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.filtered  = m_axis_tdata[OUT_W-1:0];
            got.average   = m_axis_tdata[2*OUT_W-1:OUT_W];
            got.avg_valid = m_axis_tuser[0];
            got.div_err   = m_axis_tuser[1];
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: filtered_value %0d",
                       got.filtered);
                n_fail++;
            end else begin
                want = expected_results.pop_front();
                n_results++;
                if (want.avg_valid) n_averages++;
                if (want.div_err) n_div_err++;
                if (got.filtered !== want.filtered) begin
                    $error("filtered_value: expected %0d, got %0d", want.filtered,
                           got.filtered);
                    n_fail++;
                end
                if (got.average !== want.average) begin
                    $error("average_value: expected %0d, got %0d", want.average,
                           got.average);
                    n_fail++;
                end
                if (got.avg_valid !== want.avg_valid) begin
                    $error("average_valid: expected %0d, got %0d", want.avg_valid,
                           got.avg_valid);
                    n_fail++;
                end
                if (got.div_err !== want.div_err) begin
                    $error("divide_error: expected %0d, got %0d", want.div_err,
                           got.div_err);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on cycles with no request and no result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("sensor_iir_and_window_average test failed");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        int  n_items;
        int  clear_odds;
        bit  last_phase;
        reg_offset = 0;
        reg_cpu    = 0;
        reg_shift  = 0;
        reg_window = 0;
        clear_conditioning();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
                settle();
                write_register(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].value);
            end else begin
                push_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].value,
                             DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            end
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            last_phase = (phase == RAND_PHASES - 1);
            tx_idle_on = !last_phase && ($urandom_range(0, 3) != 0);
            rx_idle_on = !last_phase && ($urandom_range(0, 3) != 0);
            // first phase fills a whole 256-sample block, so no clears there
            randomize_registers(phase == 0);
            n_items    = (phase == 0) ? 260 : 58;
            clear_odds = (phase == 0) ? 0 : $urandom_range(10, 30);
            for (int k = 0; k < n_items; k++) begin
                if (phase == 2 && k == 5) hold_req = 1'b1;
                if (phase == 3 && k == 20) settle();
                if (clear_odds != 0 && $urandom_range(1, clear_odds) == 1)
                    push_request(MODE_CLEAR, CFG_W'($urandom), 1'b0, PREDICTED);
                else
                    push_request(MODE_SAMPLE, pick_sample(), 1'b0, PREDICTED);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests (%0d clears) across %0d register writes;",
                 n_requests, n_clears, n_writes);
        $display("checked %0d results, %0d with a block average, %0d with divide error.",
                 n_results, n_averages, n_div_err);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("sensor_iir_and_window_average test passed");
        end else begin
            $display("sensor_iir_and_window_average test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/siwa_pkg.sv
rtl/siwa_div.sv
rtl/siwa_dp.sv
rtl/siwa_ctrl.sv
rtl/sensor_iir_and_window_average.sv
test/sensor_iir_and_window_average_test.sv
